>>> hw/rtl/pmit_pkg.sv
package pmit_pkg;

    localparam int COORD_W = 16;
    localparam int MASS_W  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MSC_W   = MASS_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DIAG_W  = PROD_W + 1;
    localparam int TERM_W  = DIAG_W + MSC_W;
    localparam int ACC_W   = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_ACC = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Y  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Z  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED    = 8'd3;

    localparam int ACC_XX = 0;
    localparam int ACC_YY = 1;
    localparam int ACC_ZZ = 2;
    localparam int ACC_XY = 3;
    localparam int ACC_XZ = 4;
    localparam int ACC_YZ = 5;

    localparam logic [MSC_W-1:0] UNIT_MASS = 17'd256;

    typedef struct packed {
        logic load;
        logic mul;
        logic scale;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic can_commit;
    } t_status;

endpackage

>>> hw/rtl/pmit_ctrl.sv
module pmit_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pmit_pkg::t_status i_status,
    output pmit_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_SCALE = 4'b0100,
        S_ACC   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                if (i_status.can_commit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hw/rtl/pmit_datapath.sv
module pmit_datapath #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pmit_pkg::t_cmd                         i_cmd,
    output pmit_pkg::t_status                      o_status,
    input  logic                                   i_cfg_we,
    input  logic [pmit_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pmit_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [pmit_pkg::COORD_W-1:0]    i_vertex_x,
    input  logic signed [pmit_pkg::COORD_W-1:0]    i_vertex_y,
    input  logic signed [pmit_pkg::COORD_W-1:0]    i_vertex_z,
    input  logic [pmit_pkg::MASS_W-1:0]            i_vertex_mass,
    input  logic                                   i_last_vertex,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [pmit_pkg::ACC_W-1:0]      o_inertia_xx,
    output logic signed [pmit_pkg::ACC_W-1:0]      o_inertia_yy,
    output logic signed [pmit_pkg::ACC_W-1:0]      o_inertia_zz,
    output logic signed [pmit_pkg::ACC_W-1:0]      o_inertia_xy,
    output logic signed [pmit_pkg::ACC_W-1:0]      o_inertia_xz,
    output logic signed [pmit_pkg::ACC_W-1:0]      o_inertia_yz,
    output logic                                   o_sum_overflowed
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W = pmit_pkg::DIFF_W;
    localparam int PROD_W = pmit_pkg::PROD_W;
    localparam int DIAG_W = pmit_pkg::DIAG_W;
    localparam int TERM_W = pmit_pkg::TERM_W;
    localparam int MSC_W  = pmit_pkg::MSC_W;
    localparam int ACC_W  = pmit_pkg::ACC_W;
    localparam int NACC   = pmit_pkg::NUM_ACC;

    // config
    logic signed [pmit_pkg::COORD_W-1:0] r_cx, r_cy, r_cz;
    logic                                r_weighted;

    // stage registers
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic signed [MSC_W-1:0]  r_m;
    logic                     r_last;
    logic signed [DIAG_W-1:0] r_dg [3];
    logic signed [PROD_W-1:0] r_pr [3];
    logic signed [TERM_W-1:0] r_term [NACC];

    // sums
    logic signed [ACC_W-1:0] r_acc [NACC];
    logic signed [ACC_W-1:0] n_acc [NACC];
    logic                    r_ovf;
    logic                    n_ovf;
    logic [CNT_W-1:0]        r_cnt;
    logic                    cnt_full;

    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out [NACC];
    logic                    r_out_ovf;

    logic signed [PROD_W-1:0] sq_x, sq_y, sq_z;
    logic signed [TERM_W-1:0] sc_dg [3];
    logic signed [TERM_W-1:0] sc_pr [3];

    function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                               input logic signed [TERM_W-1:0] t);
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] r;
        logic                    ov;
        b  = ACC_W'(t);
        r  = a + b;
        ov = (a[ACC_W-1] == b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1]);
        if (ov) begin
            r = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return {ov, r};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx       <= '0;
            r_cy       <= '0;
            r_cz       <= '0;
            r_weighted <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmit_pkg::REG_CENTROID_X: r_cx       <= i_cfg_data;
                pmit_pkg::REG_CENTROID_Y: r_cy       <= i_cfg_data;
                pmit_pkg::REG_CENTROID_Z: r_cz       <= i_cfg_data;
                pmit_pkg::REG_WEIGHTED:   r_weighted <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx   <= DIFF_W'(i_vertex_x) - DIFF_W'(r_cx);
            r_dy   <= DIFF_W'(i_vertex_y) - DIFF_W'(r_cy);
            r_dz   <= DIFF_W'(i_vertex_z) - DIFF_W'(r_cz);
            r_m    <= r_weighted ? {1'b0, i_vertex_mass} : pmit_pkg::UNIT_MASS;
            r_last <= i_last_vertex;
        end
    end

    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign sq_z = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dg[0] <= DIAG_W'(sq_y) + DIAG_W'(sq_z);
            r_dg[1] <= DIAG_W'(sq_x) + DIAG_W'(sq_z);
            r_dg[2] <= DIAG_W'(sq_x) + DIAG_W'(sq_y);
            r_pr[0] <= r_dx * r_dy;
            r_pr[1] <= r_dx * r_dz;
            r_pr[2] <= r_dy * r_dz;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sc_dg[i] = r_dg[i] * r_m;
            sc_pr[i] = r_pr[i] * r_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_term[pmit_pkg::ACC_XX] <= sc_dg[0];
            r_term[pmit_pkg::ACC_YY] <= sc_dg[1];
            r_term[pmit_pkg::ACC_ZZ] <= sc_dg[2];
            r_term[pmit_pkg::ACC_XY] <= -sc_pr[0];
            r_term[pmit_pkg::ACC_XZ] <= -sc_pr[1];
            r_term[pmit_pkg::ACC_YZ] <= -sc_pr[2];
        end
    end

    assign cnt_full = (r_cnt >= CNT_W'(MAX_VERTICES));

    always_comb begin
        logic [ACC_W:0] s;
        n_ovf = r_ovf | cnt_full;
        for (int i = 0; i < NACC; i++) begin
            s = sat_add(r_acc[i], r_term[i]);
            if (cnt_full) begin
                n_acc[i] = r_acc[i];
            end else begin
                n_acc[i] = s[ACC_W-1:0];
                n_ovf    = n_ovf | s[ACC_W];
            end
        end
    end

    assign o_status.can_commit = !r_last || !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NACC; i++) begin
                r_acc[i] <= '0;
            end
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                for (int i = 0; i < NACC; i++) begin
                    r_acc[i] <= '0;
                end
                r_ovf <= 1'b0;
                r_cnt <= '0;
            end else begin
                r_acc <= n_acc;
                r_ovf <= n_ovf;
                if (!cnt_full) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && r_last) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_last) begin
            r_out     <= n_acc;
            r_out_ovf <= n_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_inertia_xx     = r_out[pmit_pkg::ACC_XX];
    assign o_inertia_yy     = r_out[pmit_pkg::ACC_YY];
    assign o_inertia_zz     = r_out[pmit_pkg::ACC_ZZ];
    assign o_inertia_xy     = r_out[pmit_pkg::ACC_XY];
    assign o_inertia_xz     = r_out[pmit_pkg::ACC_XZ];
    assign o_inertia_yz     = r_out[pmit_pkg::ACC_YZ];
    assign o_sum_overflowed = r_out_ovf;

endmodule

>>> hw/rtl/point_mass_inertia_tensor_core.sv
// channel  direction  handshake                  payload
// cfg      in         i_cfg_we                   i_cfg_index, i_cfg_data
// vertex   in         i_in_valid / o_in_stall    i_vertex_x/y/z, i_vertex_mass, i_last_vertex
// result   out        o_out_valid / i_out_stall  o_inertia_*, o_sum_overflowed
//
// Each vertex passes through capture and centroid subtract, square/product,
// mass scale and saturating accumulate steps. The accumulate step of a last vertex
// waits only while the previous result is still held in the output register.
// Synchronous active-low reset clears config, sums, the vertex counter and valid.
// A stalled result stays in its output register while the next hull streams in.
module point_mass_inertia_tensor_core #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pmit_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pmit_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [pmit_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [pmit_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [pmit_pkg::COORD_W-1:0] i_vertex_z,
    input  logic [pmit_pkg::MASS_W-1:0]         i_vertex_mass,
    input  logic                                i_last_vertex,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pmit_pkg::ACC_W-1:0]   o_inertia_xx,
    output logic signed [pmit_pkg::ACC_W-1:0]   o_inertia_yy,
    output logic signed [pmit_pkg::ACC_W-1:0]   o_inertia_zz,
    output logic signed [pmit_pkg::ACC_W-1:0]   o_inertia_xy,
    output logic signed [pmit_pkg::ACC_W-1:0]   o_inertia_xz,
    output logic signed [pmit_pkg::ACC_W-1:0]   o_inertia_yz,
    output logic                                o_sum_overflowed
);

    pmit_pkg::t_cmd    cmd;
    pmit_pkg::t_status status;

    pmit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pmit_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_vertex_x       (i_vertex_x),
        .i_vertex_y       (i_vertex_y),
        .i_vertex_z       (i_vertex_z),
        .i_vertex_mass    (i_vertex_mass),
        .i_last_vertex    (i_last_vertex),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_inertia_xx     (o_inertia_xx),
        .o_inertia_yy     (o_inertia_yy),
        .o_inertia_zz     (o_inertia_zz),
        .o_inertia_xy     (o_inertia_xy),
        .o_inertia_xz     (o_inertia_xz),
        .o_inertia_yz     (o_inertia_yz),
        .o_sum_overflowed (o_sum_overflowed)
    );

endmodule
